// ===== rtl/smx_pkg.sv =====
// ----------------------------------------------------------------------------
// smx_pkg
// Shared constants and types for the SplitMix64 bounded draw block.
// ----------------------------------------------------------------------------
`default_nettype none

package smx_pkg;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned HALF_W = DATA_W / 2;
  localparam int unsigned CNT_W  = $clog2(DATA_W);

  // Weyl increment and mixing constants
  localparam logic [DATA_W-1:0] WEYL_STEP  = 64'h9E3779B97F4A7C15;
  localparam logic [DATA_W-1:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
  localparam logic [DATA_W-1:0] MIX_MUL_B  = 64'h94D049BB133111EB;
  localparam int unsigned       MIX_SHIFT_A = 30;
  localparam int unsigned       MIX_SHIFT_B = 27;
  localparam int unsigned       MIX_SHIFT_C = 31;
  localparam logic [DATA_W-1:0] SEED_RESET = 64'd1592594996;

  // Multiply sub-steps over one 64-bit truncated product
  localparam logic [1:0] MSTEP_LL   = 2'd0;
  localparam logic [1:0] MSTEP_LH   = 2'd1;
  localparam logic [1:0] MSTEP_HL   = 2'd2;
  localparam logic [1:0] MSTEP_LAST = 2'd3;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOP,
    ST_ADV,
    ST_MUL,
    ST_CHK,
    ST_MOD,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/smx_mul32.sv =====
// ----------------------------------------------------------------------------
// smx_mul32
// Shared 32x32 unsigned multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
`default_nettype none

module smx_mul32 (
  input  wire logic                         clk,
  input  wire logic [smx_pkg::HALF_W-1:0]   a_i,
  input  wire logic [smx_pkg::HALF_W-1:0]   b_i,
  output logic      [smx_pkg::DATA_W-1:0]   p_o
);

  logic [smx_pkg::DATA_W-1:0] prod;
  logic [smx_pkg::DATA_W-1:0] p_r;

  // full-width product of two half words
  assign prod = {{smx_pkg::HALF_W{1'b0}}, a_i} * {{smx_pkg::HALF_W{1'b0}}, b_i};

  always_ff @(posedge clk) begin
    p_r <= prod;
  end

  assign p_o = p_r;

endmodule

`default_nettype wire

// ===== rtl/smx_div.sv =====
// ----------------------------------------------------------------------------
// smx_div
// Restoring radix-2 divider, one quotient bit per cycle, remainder only.
// ----------------------------------------------------------------------------
`default_nettype none

module smx_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start_i,
  input  wire logic [smx_pkg::DATA_W-1:0]  dividend_i,
  input  wire logic [smx_pkg::DATA_W-1:0]  divisor_i,
  output logic                             done_o,
  output logic      [smx_pkg::DATA_W-1:0]  rem_o
);

  logic [smx_pkg::DATA_W-1:0] dvd_r;
  logic [smx_pkg::DATA_W-1:0] dvs_r;
  logic [smx_pkg::DATA_W-1:0] rem_r;
  logic [smx_pkg::CNT_W-1:0]  cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [smx_pkg::DATA_W:0]   shifted;
  logic [smx_pkg::DATA_W:0]   diff;

  // one shift-compare-subtract step
  assign shifted = {rem_r, dvd_r[smx_pkg::DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == {smx_pkg::CNT_W{1'b1}}) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start_i) begin
      dvd_r <= dividend_i;
      dvs_r <= divisor_i;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[smx_pkg::DATA_W-2:0], 1'b0};
      if (!diff[smx_pkg::DATA_W]) begin
        rem_r <= diff[smx_pkg::DATA_W-1:0];
      end else begin
        rem_r <= shifted[smx_pkg::DATA_W-1:0];
      end
    end
  end

  assign done_o = done_r;
  assign rem_o  = rem_r;

endmodule

`default_nettype wire

// ===== rtl/splitmix64_bounded_draw.sv =====
// ----------------------------------------------------------------------------
// splitmix64_bounded_draw
// SplitMix64 generator with rejection sampling for unbiased draws below n.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  in_       slave      in_tvalid/tready    tdata[63:0] bound
//  out_      master     out_tvalid/tready   tdata[63:0] draw_value, tuser[0] bound_error
//  cfg_      slave      cfg_valid/ready     cfg_data[63:0] seed_value
//
//  A draw takes the remainder of 2^64-1 by n, then tries (one Weyl add, six
//  32x32 products on the shared multiplier, one check) until a word is
//  accepted, then the final remainder; both remainders run on the one
//  bit-serial divider. A rejected try starts another; a zero bound skips all three.
//  Reset loads the counter with the reset seed; a seed write reloads it.
//  in_tready is high only in idle; a finished result waits in the output
//  register while the next beat may already be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module splitmix64_bounded_draw (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request: [63:0] bound
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,
  // result: [63:0] draw_value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [63:0] out_tdata,
  // result flag: [0] bound_error
  output logic      [0:0]  out_tuser,
  // seed register write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [63:0] cfg_data
);

  localparam int unsigned W = smx_pkg::DATA_W;
  localparam int unsigned H = smx_pkg::HALF_W;

  smx_pkg::state_t state_r, state_nxt;

  logic [W-1:0] ctr_r;
  logic [W-1:0] bound_r;
  logic [W-1:0] top_r;
  logic [W-1:0] z_r;
  logic [W-1:0] acc_r;
  logic [W-1:0] acc_nxt;
  logic [W-1:0] res_r;
  logic         err_r;
  logic [1:0]   mstep_r;
  logic         round_r;
  logic         out_valid_r;
  logic [W-1:0] out_data_r;
  logic         out_err_r;

  logic [W-1:0] ctr_step;
  logic [W-1:0] mul_k;
  logic [H-1:0] mul_a;
  logic [H-1:0] mul_b;
  logic [W-1:0] mul_p;
  logic         div_start;
  logic [W-1:0] div_dividend;
  logic [W-1:0] div_divisor;
  logic         div_done;
  logic [W-1:0] div_rem;
  logic         in_beat;
  logic         out_free;

  assign in_beat  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign ctr_step = ctr_r + smx_pkg::WEYL_STEP;

  // shared multiplier: operand half words chosen by the sub-step
  assign mul_k = round_r ? smx_pkg::MIX_MUL_B : smx_pkg::MIX_MUL_A;

  always_comb begin
    case (mstep_r)
      smx_pkg::MSTEP_LL: begin
        mul_a = z_r[H-1:0];
        mul_b = mul_k[H-1:0];
      end
      smx_pkg::MSTEP_LH: begin
        mul_a = z_r[H-1:0];
        mul_b = mul_k[W-1:H];
      end
      default: begin
        mul_a = z_r[W-1:H];
        mul_b = mul_k[H-1:0];
      end
    endcase
  end

  smx_mul32 u_mul (
    .clk (clk),
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (mul_p)
  );

  // accumulate the truncated 64-bit product one partial product at a time
  always_comb begin
    case (mstep_r)
      smx_pkg::MSTEP_LH:   acc_nxt = mul_p;
      smx_pkg::MSTEP_HL:   acc_nxt = acc_r + {mul_p[H-1:0], {H{1'b0}}};
      smx_pkg::MSTEP_LAST: acc_nxt = acc_r + {mul_p[H-1:0], {H{1'b0}}};
      default:             acc_nxt = acc_r;
    endcase
  end

  // divider operands: limit remainder at request, final remainder after check
  always_comb begin
    div_start    = 1'b0;
    div_dividend = {W{1'b1}};
    div_divisor  = bound_r;
    if (state_r == smx_pkg::ST_IDLE) begin
      div_start   = in_beat && (in_tdata != '0);
      div_divisor = in_tdata;
    end else if (state_r == smx_pkg::ST_CHK) begin
      div_start    = z_r < top_r;
      div_dividend = z_r;
    end
  end

  smx_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      smx_pkg::ST_IDLE: begin
        if (in_beat) begin
          state_nxt = (in_tdata == '0) ? smx_pkg::ST_DONE : smx_pkg::ST_TOP;
        end
      end
      smx_pkg::ST_TOP: if (div_done) state_nxt = smx_pkg::ST_ADV;
      smx_pkg::ST_ADV: state_nxt = smx_pkg::ST_MUL;
      smx_pkg::ST_MUL: begin
        if (mstep_r == smx_pkg::MSTEP_LAST && round_r) state_nxt = smx_pkg::ST_CHK;
      end
      smx_pkg::ST_CHK: state_nxt = (z_r < top_r) ? smx_pkg::ST_MOD : smx_pkg::ST_ADV;
      smx_pkg::ST_MOD: if (div_done) state_nxt = smx_pkg::ST_DONE;
      smx_pkg::ST_DONE: if (out_free) state_nxt = smx_pkg::ST_IDLE;
      default: state_nxt = smx_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smx_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Weyl counter: seed write wins over an advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r <= smx_pkg::SEED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ctr_r <= cfg_data;
    end else if (state_r == smx_pkg::ST_ADV) begin
      ctr_r <= ctr_step;
    end
  end

  // sequencer counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mstep_r <= smx_pkg::MSTEP_LL;
      round_r <= 1'b0;
    end else if (state_r == smx_pkg::ST_ADV) begin
      mstep_r <= smx_pkg::MSTEP_LL;
      round_r <= 1'b0;
    end else if (state_r == smx_pkg::ST_MUL) begin
      mstep_r <= mstep_r + 1'b1;
      if (mstep_r == smx_pkg::MSTEP_LAST) begin
        round_r <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      smx_pkg::ST_IDLE: begin
        if (in_beat) begin
          bound_r <= in_tdata;
          res_r   <= '0;
          err_r   <= (in_tdata == '0);
        end
      end
      smx_pkg::ST_TOP: begin
        // largest multiple of n not above 2^64-1
        if (div_done) top_r <= ~div_rem;
      end
      smx_pkg::ST_ADV: begin
        z_r <= ctr_step ^ (ctr_step >> smx_pkg::MIX_SHIFT_A);
      end
      smx_pkg::ST_MUL: begin
        acc_r <= acc_nxt;
        if (mstep_r == smx_pkg::MSTEP_LAST) begin
          if (round_r) begin
            z_r <= acc_nxt ^ (acc_nxt >> smx_pkg::MIX_SHIFT_C);
          end else begin
            z_r <= acc_nxt ^ (acc_nxt >> smx_pkg::MIX_SHIFT_B);
          end
        end
      end
      smx_pkg::ST_MOD: begin
        if (div_done) res_r <= div_rem;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == smx_pkg::ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == smx_pkg::ST_DONE && out_free) begin
      out_data_r <= res_r;
      out_err_r  <= err_r;
    end
  end

  assign in_tready  = (state_r == smx_pkg::ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_err_r;

  // checks
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == '0))
    else $error("bound error beat carries a non-zero draw");

  a_draw_below_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == smx_pkg::ST_DONE && !err_r) |-> (res_r < bound_r))
    else $error("draw not below its bound");

  a_accept_below_top: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == smx_pkg::ST_MOD) |-> (z_r < top_r))
    else $error("rejected word reached the final remainder");

  a_zero_keeps_ctr: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && in_tdata == '0 && !cfg_valid) |=> (ctr_r == $past(ctr_r)))
    else $error("zero bound moved the counter");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for splitmix64_bounded_draw. Request beats come from a
// queue through a clocked driver; a clocked monitor compares every result beat
// with a local SplitMix64 rejection-sampling predictor. The run covers several
// seed settings, random idling on both sides, a long result-side hold-off and
// a full drain in the middle of each phase.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [smx_pkg::DATA_W-1:0] ALL_ONES   = '1;
  localparam logic [smx_pkg::DATA_W-1:0] TOP_BIT    =
    {1'b1, {(smx_pkg::DATA_W-1){1'b0}}};
  localparam int                PHASE_LEN  = 380;
  localparam int                HOLD_LEN   = 1500;
  localparam int                QUIET_FROM = 600;
  localparam int                QUIET_TO   = 900;

  typedef struct packed {
    logic [smx_pkg::DATA_W-1:0] value;
    logic                       err;
  } draw_t;

  logic                       clk;
  logic                       rst_n      = 1'b0;
  logic                       in_tvalid  = 1'b0;
  logic                       in_tready;
  logic [smx_pkg::DATA_W-1:0] in_tdata   = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [smx_pkg::DATA_W-1:0] out_tdata;
  logic [0:0]                 out_tuser;
  logic                       cfg_valid  = 1'b0;
  logic                       cfg_ready;
  logic [smx_pkg::DATA_W-1:0] cfg_data   = '0;

  // predictor state and bookkeeping
  logic [smx_pkg::DATA_W-1:0] weyl_state = smx_pkg::SEED_RESET;
  logic [smx_pkg::DATA_W-1:0] pending_bounds[$];
  draw_t             draws_due[$];
  int                bounds_sent  = 0;
  int                draws_seen   = 0;
  int                mismatches   = 0;
  int                hold_left    = 0;
  logic              hold_done    = 1'b0;

  splitmix64_bounded_draw dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),    // [63:0] bound
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),   // [63:0] draw_value
    .out_tuser (out_tuser),   // [0] bound_error
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // SplitMix64 finaliser
  function automatic logic [smx_pkg::DATA_W-1:0] splitmix_mix(
    input logic [smx_pkg::DATA_W-1:0] z);
    z = (z ^ (z >> smx_pkg::MIX_SHIFT_A)) * smx_pkg::MIX_MUL_A;
    z = (z ^ (z >> smx_pkg::MIX_SHIFT_B)) * smx_pkg::MIX_MUL_B;
    return z ^ (z >> smx_pkg::MIX_SHIFT_C);
  endfunction

  // Work out one draw and advance the counter past every rejected try
  task automatic predict_draw(input logic [smx_pkg::DATA_W-1:0] n);
    draw_t                      d;
    logic [smx_pkg::DATA_W-1:0] top;
    logic [smx_pkg::DATA_W-1:0] r;
    if (n == '0) begin
      d.value = '0;
      d.err   = 1'b1;
    end else begin
      top = ALL_ONES - (ALL_ONES % n);
      do begin
        weyl_state = weyl_state + smx_pkg::WEYL_STEP;
        r = splitmix_mix(weyl_state);
      end while (r > top - 64'd1);
      d.value = r % n;
      d.err   = 1'b0;
    end
    draws_due.push_back(d);
  endtask

  // Bound mix: small, powers of two, just above half range (heavy rejection),
  // near the top, random widths, full random, and the odd zero
  function automatic logic [smx_pkg::DATA_W-1:0] pick_bound();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 3)
      return '0;
    else if (sel < 25)
      return smx_pkg::DATA_W'($urandom_range(1000, 1));
    else if (sel < 40)
      return TOP_BIT >> $urandom_range(smx_pkg::DATA_W-1);
    else if (sel < 55)
      return TOP_BIT + smx_pkg::DATA_W'($urandom_range(32'hFFFF_FFFF, 1));
    else if (sel < 65)
      return ALL_ONES - smx_pkg::DATA_W'($urandom_range(1000));
    else if (sel < 75)
      return {$urandom, $urandom} >> $urandom_range(smx_pkg::DATA_W-1);
    else
      return {$urandom, $urandom};
  endfunction

  // Request driver: predicts at each accepted beat, then offers the next bound
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid && in_tready) begin
        predict_draw(in_tdata);
        bounds_sent <= bounds_sent + 1;
      end
      if (pending_bounds.size() != 0 &&
          ((bounds_sent >= QUIET_FROM && bounds_sent < QUIET_TO) ||
           $urandom_range(99) >= 18)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pending_bounds.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result-side ready: random idling, one long hold-off, one quiet stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!hold_done && draws_seen >= 250) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_LEN;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= (draws_seen >= QUIET_FROM && draws_seen < QUIET_TO) ||
                    ($urandom_range(99) >= 18);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    draw_t d;
    int    bad;
    bad = 0;
    if (rst_n && out_tvalid && out_tready) begin
      draws_seen <= draws_seen + 1;
      if (draws_due.size() == 0) begin
        $error("unexpected result beat: draw_value %h bound_error %b",
               out_tdata, out_tuser[0]);
        bad = bad + 1;
      end else begin
        d = draws_due.pop_front();
        if (out_tdata !== d.value) begin
          $error("draw_value: expected %h, got %h", d.value, out_tdata);
          bad = bad + 1;
        end
        if (out_tuser[0] !== d.err) begin
          $error("bound_error: expected %b, got %b", d.err, out_tuser[0]);
          bad = bad + 1;
        end
      end
      mismatches <= mismatches + bad;
    end
  end

  // Wait until every queued bound has gone in and every draw has come back
  task automatic wait_drained();
    while (pending_bounds.size() != 0 || in_tvalid || draws_due.size() != 0)
      @(posedge clk);
  endtask

  // Seed write over the config channel; reloads the counter
  task automatic write_seed(input logic [smx_pkg::DATA_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    weyl_state = v;
  endtask

  // Stimulus sequence
  initial begin
    logic [smx_pkg::DATA_W-1:0] seeds[5];
    seeds[1] = '0;
    seeds[2] = ALL_ONES;
    seeds[3] = {$urandom, $urandom};
    seeds[4] = {$urandom, $urandom};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero, one, tiny, powers of two, worst-case rejection, extremes
    pending_bounds.push_back('0);
    pending_bounds.push_back(64'd1);
    pending_bounds.push_back(64'd2);
    pending_bounds.push_back(64'd3);
    pending_bounds.push_back(64'd7);
    pending_bounds.push_back(64'd10);
    pending_bounds.push_back(64'h0000_0001_0000_0000);
    pending_bounds.push_back(64'h0000_0001_0000_0001);
    pending_bounds.push_back(TOP_BIT - 64'd1);
    pending_bounds.push_back(TOP_BIT);
    pending_bounds.push_back(TOP_BIT + 64'd1);
    pending_bounds.push_back(TOP_BIT + 64'd1);
    pending_bounds.push_back(ALL_ONES - 64'd1);
    pending_bounds.push_back(ALL_ONES);
    pending_bounds.push_back(64'h5555_5555_5555_5555);
    pending_bounds.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    pending_bounds.push_back('0);
    pending_bounds.push_back(64'd1);

    for (int ph = 0; ph < 5; ph++) begin
      if (ph != 0) begin
        wait_drained();
        write_seed(seeds[ph]);
      end
      for (int i = 0; i < PHASE_LEN; i++) begin
        // sender pause mid-phase until every draw is back
        if (i == PHASE_LEN / 2)
          wait_drained();
        pending_bounds.push_back(pick_bound());
      end
    end

    wait_drained();
    repeat (400) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Watchdog
  initial begin
    #60_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
